/* rtl/skf_pkg.sv */
// Shared types and constants for the scalar Kalman filter core.
// No dependencies; used by skf_divider, skf_mult and scalar_kalman_filter_core.
`default_nettype none

package skf_pkg;

    // Fraction bits of estimates, variances and noise values (Q16.16 by default).
    localparam int FRAC_BITS = 16;
    // The gain is always Q1.16 (unsigned, 17 bits), so 1.0 is 2^16.
    localparam int GAIN_BITS = 16;

    localparam int DATA_W = 32;
    localparam int GAIN_W = GAIN_BITS + 1;
    localparam int DEN_W  = DATA_W + 1;
    localparam int REM_W  = DEN_W + 1;

    // Multiplier operand and product widths.
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = DATA_W + 2;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Rounded estimate step width after dropping the gain fraction.
    localparam int DELTA_W = MUL_P_W - GAIN_BITS;

    // One quotient bit per divider step.
    localparam int DIV_STEPS = GAIN_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;
    localparam logic [DATA_W-1:0] VALUE_ONE = DATA_W'(1) << FRAC_BITS;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_ESTIMATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VARIANCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE      = 2'd3;

    // Request from the sequencer to the gain divider.
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DEN_W-1:0]  divisor;
    } div_req_t;

    // Answer from the gain divider.
    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_PRED    = 10'b00_0000_0010,
        ST_DENOM   = 10'b00_0000_0100,
        ST_DIV     = 10'b00_0000_1000,
        ST_MUL_EST = 10'b00_0001_0000,
        ST_RND     = 10'b00_0010_0000,
        ST_SAT     = 10'b00_0100_0000,
        ST_MUL_VAR = 10'b00_1000_0000,
        ST_VAR     = 10'b01_0000_0000,
        ST_DONE    = 10'b10_0000_0000
    } state_t;

endpackage

`default_nettype wire

/* rtl/skf_divider.sv */
// Restoring divider that forms the Kalman gain, one quotient bit per cycle.
// Depends on skf_pkg for widths and the request/answer structs.
`default_nettype none

module skf_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire skf_pkg::div_req_t req,
    output skf_pkg::div_rsp_t      rsp
);

    logic [skf_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [skf_pkg::GAIN_W-1:0]    quot_reg, quot_next;
    logic [skf_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          done_reg, done_next;

    logic [skf_pkg::REM_W:0]       diff;
    logic                          q_bit;
    logic [skf_pkg::DEN_W-1:0]     kept;

    // The dividend is pp * 2^16 and pp never exceeds the divisor, so the
    // first step compares pp itself and later steps shift in zeros.
    always_comb begin
        diff      = {1'b0, rem_reg} - {2'b00, req.divisor};
        q_bit     = ~diff[skf_pkg::REM_W];
        kept      = q_bit ? diff[skf_pkg::DEN_W-1:0] : rem_reg[skf_pkg::DEN_W-1:0];
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = {2'b00, req.dividend};
            quot_next = '0;
            cnt_next  = skf_pkg::DIV_CNT_W'(skf_pkg::DIV_STEPS);
        end else if (cnt_reg != '0) begin
            rem_next  = {kept, 1'b0};
            quot_next = {quot_reg[skf_pkg::GAIN_W-2:0], q_bit};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == skf_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

`default_nettype wire

/* rtl/skf_mult.sv */
// Shared signed multiplier with a registered product, used for both the
// estimate and the variance update. Depends on skf_pkg for widths.
`default_nettype none

module skf_mult (
    input  wire logic                               aclk,
    input  wire logic signed [skf_pkg::MUL_A_W-1:0] op_a,
    input  wire logic signed [skf_pkg::MUL_B_W-1:0] op_b,
    output logic signed [skf_pkg::MUL_P_W-1:0]      product
);

    logic signed [skf_pkg::MUL_P_W-1:0] prod_reg, prod_next;

    always_comb begin
        prod_next = skf_pkg::MUL_P_W'(op_a) * skf_pkg::MUL_P_W'(op_b);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign product = prod_reg;

endmodule

`default_nettype wire

/* rtl/scalar_kalman_filter_core.sv */
// Top level of the scalar Kalman filter core: sequencer, state and ports.
// Depends on skf_pkg, skf_divider and skf_mult.
//
//  Channel   Direction  Handshake            Content
//  s_        in         s_tvalid / s_tready  measurement (signed Q16.16)
//  m_        out        m_tvalid / m_tready  estimate, variance, gain; tuser flag
//  cfg_      in         cfg_wr_en only       register index and write data
//
// Each measurement passes from acceptance to the result register through a
// predict step, a denominator step, the bit-serial gain divider (17 quotient
// bits at one per cycle, then the quotient is handed over), and the estimate
// multiply, rounding, saturation, variance multiply and variance update, which
// share one multiplier. A zero denominator skips the divider and multiplier.
// s_tready is high only while the sequencer is idle.
// The result register holds a finished transaction while m_tready is low, so
// a new measurement is taken meanwhile; the next result waits for it.
// Reset is synchronous and active low; it restores the estimate to 0 and the
// variance and measurement noise to 1.0, and process noise to 0.
`default_nettype none

module scalar_kalman_filter_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [31:0] measurement
    input  wire logic [31:0]                       s_tdata,

    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [31:0] estimate, [63:32] variance, [80:64] gain, [87:81] zero fill
    output logic [87:0]                            m_tdata,
    // [0] zero_denominator
    output logic                                   m_tuser,

    input  wire logic                              cfg_wr_en,
    input  wire logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [skf_pkg::DATA_W-1:0]        cfg_wdata
);

    localparam int DW = skf_pkg::DATA_W;
    localparam int SUM_W = DW + 5;

    skf_pkg::state_t state_reg, state_next;

    // Filter state and noise settings.
    logic signed [DW-1:0] est_reg, est_next;
    logic [DW-1:0]        var_reg, var_next;
    logic [DW-1:0]        rnoise_reg, rnoise_next;
    logic [DW-1:0]        qnoise_reg, qnoise_next;

    // Per-transaction working registers.
    logic signed [DW-1:0]                meas_reg, meas_next;
    logic signed [DW:0]                  innov_reg, innov_next;
    logic [DW-1:0]                       pp_reg, pp_next;
    logic [skf_pkg::DEN_W-1:0]           den_reg, den_next;
    logic [skf_pkg::GAIN_W-1:0]          gain_reg, gain_next;
    logic                                zd_reg, zd_next;
    logic signed [skf_pkg::DELTA_W-1:0]  delta_reg, delta_next;

    // Output register.
    logic                        m_valid_reg, m_valid_next;
    logic [DW-1:0]               m_est_reg, m_est_next;
    logic [DW-1:0]               m_var_reg, m_var_next;
    logic [skf_pkg::GAIN_W-1:0]  m_gain_reg, m_gain_next;
    logic                        m_zd_reg, m_zd_next;

    skf_pkg::div_req_t div_req;
    skf_pkg::div_rsp_t div_rsp;

    logic signed [skf_pkg::MUL_A_W-1:0] mul_a;
    logic signed [skf_pkg::MUL_B_W-1:0] mul_b;
    logic signed [skf_pkg::MUL_P_W-1:0] mul_p;

    logic [DW:0]               pred_sum;
    logic [skf_pkg::DEN_W-1:0] den_sum;
    logic signed [skf_pkg::MUL_P_W-1:0] rounded;
    logic signed [SUM_W-1:0]   est_sum;
    logic                      in_fire;
    logic                      out_free;

    skf_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    skf_mult u_mult (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // The divider reads the denominator from its register during every step.
    assign div_req.start    = (state_reg == skf_pkg::ST_DENOM) && (den_sum != '0);
    assign div_req.dividend = pp_reg;
    assign div_req.divisor  = den_reg;

    // The shared multiplier forms gain * innovation first, then
    // (1 - gain) * predicted variance; the product is registered.
    always_comb begin
        if (state_reg == skf_pkg::ST_MUL_EST) begin
            mul_a = {1'b0, gain_reg};
            mul_b = skf_pkg::MUL_B_W'(innov_reg);
        end else begin
            mul_a = {1'b0, skf_pkg::GAIN_ONE - gain_reg};
            mul_b = {2'b00, pp_reg};
        end
    end

    always_comb begin
        pred_sum = {1'b0, var_reg} + {1'b0, qnoise_reg};
        den_sum  = {1'b0, pp_reg} + {1'b0, rnoise_reg};
        // Round half up before dropping the gain fraction.
        rounded  = mul_p + skf_pkg::MUL_P_W'(1 << (skf_pkg::GAIN_BITS - 1));
        est_sum  = SUM_W'(est_reg) + SUM_W'(delta_reg);
    end

    always_comb begin
        state_next   = state_reg;
        est_next     = est_reg;
        var_next     = var_reg;
        rnoise_next  = rnoise_reg;
        qnoise_next  = qnoise_reg;
        meas_next    = meas_reg;
        innov_next   = innov_reg;
        pp_next      = pp_reg;
        den_next     = den_reg;
        gain_next    = gain_reg;
        zd_next      = zd_reg;
        delta_next   = delta_reg;
        m_valid_next = m_valid_reg;
        m_est_next   = m_est_reg;
        m_var_next   = m_var_reg;
        m_gain_next  = m_gain_reg;
        m_zd_next    = m_zd_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        // Configuration writes are to arrive only while the block is idle; the user must ensure it, the block does not.
        if (cfg_wr_en) begin
            unique case (cfg_index)
                skf_pkg::CFG_INIT_ESTIMATE: est_next    = cfg_wdata;
                skf_pkg::CFG_INIT_VARIANCE: var_next    = cfg_wdata;
                skf_pkg::CFG_MEAS_NOISE:    rnoise_next = cfg_wdata;
                skf_pkg::CFG_PROC_NOISE:    qnoise_next = cfg_wdata;
                default:                    ;
            endcase
        end

        unique case (state_reg)
            skf_pkg::ST_IDLE: begin
                if (in_fire) begin
                    meas_next  = s_tdata;
                    state_next = skf_pkg::ST_PRED;
                end
            end
            skf_pkg::ST_PRED: begin
                // Predicted variance saturates at all ones.
                pp_next    = pred_sum[DW] ? '1 : pred_sum[DW-1:0];
                innov_next = (DW+1)'(meas_reg) - (DW+1)'(est_reg);
                state_next = skf_pkg::ST_DENOM;
            end
            skf_pkg::ST_DENOM: begin
                den_next = den_sum;
                if (den_sum == '0) begin
                    // Zero denominator: keep the state and flag the result.
                    gain_next  = '0;
                    zd_next    = 1'b1;
                    state_next = skf_pkg::ST_DONE;
                end else begin
                    zd_next    = 1'b0;
                    state_next = skf_pkg::ST_DIV;
                end
            end
            skf_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    gain_next  = div_rsp.quotient;
                    state_next = skf_pkg::ST_MUL_EST;
                end
            end
            skf_pkg::ST_MUL_EST: begin
                state_next = skf_pkg::ST_RND;
            end
            skf_pkg::ST_RND: begin
                delta_next = rounded[skf_pkg::MUL_P_W-1:skf_pkg::GAIN_BITS];
                state_next = skf_pkg::ST_SAT;
            end
            skf_pkg::ST_SAT: begin
                // Saturate the updated estimate to the signed 32-bit range.
                if (est_sum[SUM_W-1] && !(&est_sum[SUM_W-2:DW-1])) begin
                    est_next = {1'b1, {(DW-1){1'b0}}};
                end else if (!est_sum[SUM_W-1] && (|est_sum[SUM_W-2:DW-1])) begin
                    est_next = {1'b0, {(DW-1){1'b1}}};
                end else begin
                    est_next = est_sum[DW-1:0];
                end
                state_next = skf_pkg::ST_MUL_VAR;
            end
            skf_pkg::ST_MUL_VAR: begin
                state_next = skf_pkg::ST_VAR;
            end
            skf_pkg::ST_VAR: begin
                var_next   = mul_p[skf_pkg::GAIN_BITS +: DW];
                state_next = skf_pkg::ST_DONE;
            end
            skf_pkg::ST_DONE: begin
                // Wait here only if the previous result has not been taken.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_est_next   = est_reg;
                    m_var_next   = var_reg;
                    m_gain_next  = gain_reg;
                    m_zd_next    = zd_reg;
                    state_next   = skf_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = skf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= skf_pkg::ST_IDLE;
            est_reg     <= '0;
            var_reg     <= skf_pkg::VALUE_ONE;
            rnoise_reg  <= skf_pkg::VALUE_ONE;
            qnoise_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            est_reg     <= est_next;
            var_reg     <= var_next;
            rnoise_reg  <= rnoise_next;
            qnoise_reg  <= qnoise_next;
            m_valid_reg <= m_valid_next;
        end
        meas_reg   <= meas_next;
        innov_reg  <= innov_next;
        pp_reg     <= pp_next;
        den_reg    <= den_next;
        gain_reg   <= gain_next;
        zd_reg     <= zd_next;
        delta_reg  <= delta_next;
        m_est_reg  <= m_est_next;
        m_var_reg  <= m_var_next;
        m_gain_reg <= m_gain_next;
        m_zd_reg   <= m_zd_next;
    end

    assign s_tready = (state_reg == skf_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_gain_reg, m_var_reg, m_est_reg};
    assign m_tuser  = m_zd_reg;

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for scalar_kalman_filter_core: a fixed-point filter predictor
// in a small scoreboard class, stream drivers with random idling, and register writes.
// Depends on skf_pkg and the core RTL only.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skf_pkg::*;

    localparam int    CYCLE_LIMIT   = 1_500_000;
    localparam int    ITEM_TARGET   = 1900;
    localparam int    HOLD_CYCLES   = 300;
    localparam int    DRAIN_CYCLES  = 40;
    localparam int    REPORT_LIMIT  = 100;
    localparam longint EST_MAX      = 64'sh0000_0000_7FFF_FFFF;
    localparam longint EST_MIN      = 64'shFFFF_FFFF_8000_0000;

    // Register indexes in the order the programming task walks them.
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] = '{
        CFG_INIT_ESTIMATE, CFG_INIT_VARIANCE, CFG_MEAS_NOISE, CFG_PROC_NOISE
    };

    // One filter update as it appears on the result channel.
    typedef struct packed {
        logic [DATA_W-1:0] estimate;
        logic [DATA_W-1:0] variance;
        logic [GAIN_W-1:0] gain;
        logic              zero_den;
    } filter_update_t;

    // Predicts every filter update from the accepted measurements and checks
    // the result transactions against those predictions in order.
    class kalman_scoreboard;
        logic signed [DATA_W-1:0] estimate_q;
        logic [DATA_W-1:0]        variance_q;
        logic [DATA_W-1:0]        meas_noise;
        logic [DATA_W-1:0]        proc_noise;
        filter_update_t           pending_updates[$];
        int                       error_count;

        function new();
            estimate_q  = '0;
            variance_q  = VALUE_ONE;
            meas_noise  = VALUE_ONE;
            proc_noise  = '0;
            error_count = 0;
        endfunction

        // Writing an initial value also loads the matching state.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                CFG_INIT_ESTIMATE: estimate_q = value;
                CFG_INIT_VARIANCE: variance_q = value;
                CFG_MEAS_NOISE:    meas_noise = value;
                CFG_PROC_NOISE:    proc_noise = value;
                default: ;
            endcase
        endfunction

        // One predict/update step for an accepted measurement.
        function void note_measurement(logic [DATA_W-1:0] z);
            filter_update_t upd;
            logic [DATA_W:0]   pp_sum;
            logic [DATA_W-1:0] pp;
            logic [DATA_W+1:0] den;
            logic [63:0]       k;
            longint            innov;
            longint            prod;
            longint            delta;
            longint            next_est;
            pp_sum = {1'b0, variance_q} + {1'b0, proc_noise};
            pp     = pp_sum[DATA_W] ? {DATA_W{1'b1}} : pp_sum[DATA_W-1:0];
            den    = {2'b00, pp} + {2'b00, meas_noise};
            if (den == '0) begin
                // Nothing to divide by: the state is kept and flagged.
                upd.estimate = estimate_q;
                upd.variance = variance_q;
                upd.gain     = '0;
                upd.zero_den = 1'b1;
            end else begin
                k = (64'(pp) << GAIN_BITS) / 64'(den);
                if (k > 64'(GAIN_ONE)) begin
                    k = 64'(GAIN_ONE);
                end
                innov    = longint'($signed(z)) - longint'(estimate_q);
                prod     = $signed(k) * innov;
                // Round half up, then drop the gain fraction.
                delta    = (prod + (64'sd1 <<< (GAIN_BITS - 1))) >>> GAIN_BITS;
                next_est = longint'(estimate_q) + delta;
                if (next_est > EST_MAX) begin
                    next_est = EST_MAX;
                end else if (next_est < EST_MIN) begin
                    next_est = EST_MIN;
                end
                estimate_q   = next_est[DATA_W-1:0];
                variance_q   = 32'(((64'(GAIN_ONE) - k) * 64'(pp)) >> GAIN_BITS);
                upd.estimate = estimate_q;
                upd.variance = variance_q;
                upd.gain     = k[GAIN_W-1:0];
                upd.zero_den = 1'b0;
            end
            pending_updates.push_back(upd);
        endfunction

        function void report(string field, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
            error_count++;
            // Keep the log bounded if the core goes badly wrong.
            if (error_count <= REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
            end
        endfunction

        function void check_result(logic [87:0] data, logic flag);
            filter_update_t want;
            if (pending_updates.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("%0t: result with no measurement pending, actual %h", $time, data);
                end
                return;
            end
            want = pending_updates.pop_front();
            if (data[31:0] !== want.estimate) report("estimate", want.estimate, data[31:0]);
            if (data[63:32] !== want.variance) report("variance", want.variance, data[63:32]);
            if (data[80:64] !== want.gain) report("gain", 32'(want.gain), 32'(data[80:64]));
            if (flag !== want.zero_den) report("zero_denominator", 32'(want.zero_den), 32'(flag));
        endfunction

        function int pending();
            return pending_updates.size();
        endfunction
    endclass

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [87:0]       m_tdata;
    logic              m_tuser;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_INIT_ESTIMATE;
    logic [DATA_W-1:0] cfg_wdata = '0;

    kalman_scoreboard sb = new();

    // Idling controls shared by the stimulus and the receiver process.
    bit tx_gaps_on    = 1'b0;
    bit rx_stalls_on  = 1'b0;
    bit hold_off_req  = 1'b0;
    int items_sent    = 0;
    int cycle_count   = 0;

    scalar_kalman_filter_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Everything the scoreboard sees is taken at the rising edge, so register
    // writes, accepted measurements and accepted results line up with the core.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                sb.write_reg(cfg_index, cfg_wdata);
            end
            if (s_tvalid && s_tready) begin
                sb.note_measurement(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata, m_tuser);
            end
        end
    end

    // Mostly zero or short, now and then a long idle stretch.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: random back-pressure, plus one long hold-off on request so that
    // the result register fills, the core takes one more measurement and then
    // drops s_tready while the sender keeps offering.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                stall_left   = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end else if (stall_left == 0 && rx_stalls_on && $urandom_range(0, 5) == 0) begin
                stall_left = idle_length();
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offers one measurement and holds it until the core takes it; valid stays
    // high into the next transaction unless a gap follows.
    task automatic send_measurement(input logic [31:0] z);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= z;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
        gap = tx_gaps_on ? idle_length() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Stops offering and waits until every predicted update has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Writes the registers picked by sel (bit i means register i) once the
    // core is idle; every result carries one, so an empty queue means idle.
    task automatic program_filter(input logic [3:0] sel, input logic [31:0] est0,
                                  input logic [31:0] var0, input logic [31:0] r_val,
                                  input logic [31:0] q_val);
        logic [31:0] vals [4];
        vals = '{est0, var0, r_val, q_val};
        wait_drained();
        for (int i = 0; i < 4; i++) begin
            if (sel[i]) begin
                cfg_wr_en <= 1'b1;
                cfg_index <= REG_ORDER[i];
                cfg_wdata <= vals[i];
                @(negedge aclk);
            end
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Register values: the extremes, a full-range draw, and mostly sensible
    // noise levels up to 16.0.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(1, 32'h0010_0000);
        endcase
    endfunction

    // Measurements are mostly a noisy reading around one value, which is what
    // lets the filter settle; the rest are full-range draws and extremes.
    function automatic logic [31:0] pick_measurement(logic [31:0] center, int spread);
        logic [31:0] mask;
        int          r;
        mask = (32'd1 << spread) - 32'd1;
        r    = $urandom_range(0, 9);
        if (r < 7) return center + ($urandom & mask) - (mask >> 1);
        if (r < 9) return $urandom;
        return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    initial begin
        logic [31:0] center;
        int          spread;
        int          phase_len;
        int          phase;
        logic [3:0]  sel;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset values (gain one half): measurement extremes and sign changes.
        send_measurement(32'h7FFF_FFFF);
        send_measurement(32'h8000_0000);
        send_measurement(32'h0000_0000);
        send_measurement(32'hFFFF_FFFF);
        send_measurement(32'h0001_0000);

        // Zero denominator: variance and both noises zero keep the state.
        program_filter(4'b1111, 32'h0005_0000, 32'h0, 32'h0, 32'h0);
        send_measurement(32'h1234_5678);
        send_measurement(32'h8000_0000);
        send_measurement(32'h7FFF_FFFF);
        // With no measurement noise the gain is one and the variance collapses
        // to zero, so the step after that hits the zero denominator again.
        program_filter(4'b0010, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
        send_measurement(32'hFFF0_0000);
        send_measurement(32'h0000_0001);

        // Predicted variance saturates at all ones.
        program_filter(4'b1111, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_measurement(32'h8000_0000);
        send_measurement(32'h7FFF_FFFF);
        send_measurement(32'h8000_0000);

        // Full gain from the most negative estimate to the most positive
        // measurement and back: the widest estimate swings.
        program_filter(4'b1111, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_measurement(32'h7FFF_FFFF);
        send_measurement(32'h8000_0000);
        send_measurement(32'h7FFF_FFFF);

        // Almost no gain: tiny variance against huge measurement noise.
        program_filter(4'b1111, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
        send_measurement(32'h7FFF_FFFF);
        send_measurement(32'h0000_0001);

        // Random phases, each with its own settings and idling pattern. Some
        // phases leave the initial values alone so the state carries over.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            sel = (phase % 3 == 0) ? 4'b1111 : 4'($urandom_range(1, 15));
            program_filter(sel, pick_value(), pick_value(), pick_value(), pick_value());
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            if (phase == 1 || phase == 2) begin
                // One phase for the long hold-off, one with no idling at all.
                tx_gaps_on   = 1'b0;
                rx_stalls_on = 1'b0;
            end
            center    = $urandom;
            spread    = $urandom_range(4, 24);
            phase_len = $urandom_range(40, 200);
            for (int n = 0; n < phase_len; n++) begin
                if (phase == 1 && n == 10) begin
                    hold_off_req = 1'b1;
                end
                if (phase == 3 && n == phase_len / 2) begin
                    wait_drained();
                end
                send_measurement(pick_measurement(center, spread));
            end
            phase++;
        end

        // Let the last updates come back, then watch for stray results.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
